/* rtl/hmdq_pkg.sv */
// Shared types and constants for the hand motion direction quantizer.
// Item structs, direction codes, register indexes and sector-edge constants.
// No dependencies.
package hmdq_pkg;

   localparam int POS_BITS  = 16;
   localparam int NUM_HANDS = 2;
   localparam int HAND_W    = 1;
   localparam int CONF_W    = 8;
   localparam int STILL_W   = 10;

   localparam int POSN_W = POS_BITS + 1;
   localparam int DX_W   = POS_BITS + 2;
   localparam int DY_W   = POS_BITS + 1;
   localparam int MAG_W  = POS_BITS;
   localparam int PROD_W = MAG_W + 18;

   localparam logic [17:0] TAN_LO = 18'd27146;
   localparam logic [17:0] TAN_HI = 18'd158218;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_XY_STILL = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_Z_STILL  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MIN_CONF = 2'd2;

   localparam logic [STILL_W-1:0] XY_STILL_RST = 10'd2;
   localparam logic [STILL_W-1:0] Z_STILL_RST  = 10'd20;
   localparam logic [CONF_W-1:0]  MIN_CONF_RST = 8'd128;

   typedef enum logic [3:0] {
      PLANE_VOID       = 4'd0,
      PLANE_STILL      = 4'd1,
      PLANE_RIGHT      = 4'd2,
      PLANE_UP_RIGHT   = 4'd3,
      PLANE_UP         = 4'd4,
      PLANE_UP_LEFT    = 4'd5,
      PLANE_LEFT       = 4'd6,
      PLANE_DOWN_LEFT  = 4'd7,
      PLANE_DOWN       = 4'd8,
      PLANE_DOWN_RIGHT = 4'd9
   } plane_dir_type;

   typedef enum logic [1:0] {
      DEPTH_EMPTY    = 2'd0,
      DEPTH_CENTRE   = 2'd1,
      DEPTH_FORWARD  = 2'd2,
      DEPTH_BACKWARD = 2'd3
   } depth_dir_type;

   typedef struct packed {
      logic [HAND_W-1:0]          hand;
      logic                       tracked;
      logic [CONF_W-1:0]          confidence;
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic signed [POS_BITS-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [HAND_W-1:0] out_hand;
      logic              updated;
      plane_dir_type     dir_plane;
      depth_dir_type     dir_depth;
   } rsp_type;

   typedef struct packed {
      logic [STILL_W-1:0] xy_still_mm;
      logic [STILL_W-1:0] z_still_mm;
      logic [CONF_W-1:0]  min_confidence;
   } cfg_type;

   typedef struct packed {
      logic [HAND_W-1:0] hand;
      logic              updated;
      logic              have_prev;
      logic [MAG_W-1:0]  ax;
      logic [MAG_W-1:0]  ay;
      logic [MAG_W-1:0]  az;
      logic              dx_pos;
      logic              dy_pos;
      logic              dz_pos;
   } delta_type;

endpackage

/* rtl/hmdq_csr.sv */
// Configuration registers behind the APB-style port.
// Depends on hmdq_pkg.
module hmdq_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hmdq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hmdq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hmdq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output hmdq_pkg::cfg_type              cfg
);
   import hmdq_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_XY_STILL: cfg_in.xy_still_mm    = pwdata[STILL_W-1:0];
            REG_Z_STILL:  cfg_in.z_still_mm     = pwdata[STILL_W-1:0];
            REG_MIN_CONF: cfg_in.min_confidence = pwdata[CONF_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.xy_still_mm    <= XY_STILL_RST;
         cfg_ff.z_still_mm     <= Z_STILL_RST;
         cfg_ff.min_confidence <= MIN_CONF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_XY_STILL: prdata = CSR_DATA_W'(cfg_ff.xy_still_mm);
         REG_Z_STILL:  prdata = CSR_DATA_W'(cfg_ff.z_still_mm);
         REG_MIN_CONF: prdata = CSR_DATA_W'(cfg_ff.min_confidence);
         default:      prdata = '0;
      endcase
   end

endmodule

/* rtl/hmdq_delta.sv */
// Input register, per-hand previous positions and the motion delta stage.
// Depends on hmdq_pkg.
module hmdq_delta (
   input  logic                  clock,
   input  logic                  reset,
   input  hmdq_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hmdq_pkg::req_type     req_data,
   output logic                  mid_valid,
   input  logic                  mid_ready,
   output hmdq_pkg::delta_type   mid_data
);
   import hmdq_pkg::*;

   logic                     in_vld_ff;
   req_type                  in_ff;
   logic                     mid_vld_ff;
   delta_type                mid_ff;
   delta_type                mid_in;

   logic signed [POSN_W-1:0] prev_x_ff [NUM_HANDS];
   logic signed [POS_BITS-1:0] prev_y_ff [NUM_HANDS];
   logic signed [POSN_W-1:0] prev_z_ff [NUM_HANDS];
   logic                     prev_valid_ff [NUM_HANDS];

   logic                     mid_free;
   logic                     in_free;
   logic                     sample_ok;
   logic signed [POSN_W-1:0] x_neg;
   logic signed [POSN_W-1:0] z_neg;
   logic signed [DX_W-1:0]   dx;
   logic signed [DY_W-1:0]   dy;
   logic signed [DX_W-1:0]   dz;
   logic [DX_W-1:0]          ax_full;
   logic [DY_W-1:0]          ay_full;
   logic [DX_W-1:0]          az_full;

   assign mid_free  = !mid_vld_ff || mid_ready;
   assign in_free   = !in_vld_ff || mid_free;
   assign req_stall = !in_free;
   assign mid_valid = mid_vld_ff;
   assign mid_data  = mid_ff;

   assign sample_ok = in_ff.tracked && (in_ff.confidence > cfg.min_confidence);
   assign x_neg     = -$signed({in_ff.pos_x[POS_BITS-1], in_ff.pos_x});
   assign z_neg     = -$signed({in_ff.pos_z[POS_BITS-1], in_ff.pos_z});

   always_comb begin
      dx = $signed({x_neg[POSN_W-1], x_neg})
         - $signed({prev_x_ff[in_ff.hand][POSN_W-1], prev_x_ff[in_ff.hand]});
      dy = $signed({in_ff.pos_y[POS_BITS-1], in_ff.pos_y})
         - $signed({prev_y_ff[in_ff.hand][POS_BITS-1], prev_y_ff[in_ff.hand]});
      dz = $signed({z_neg[POSN_W-1], z_neg})
         - $signed({prev_z_ff[in_ff.hand][POSN_W-1], prev_z_ff[in_ff.hand]});
      ax_full = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
      ay_full = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
      az_full = dz[DX_W-1] ? DX_W'(-dz) : DX_W'(dz);

      mid_in.hand      = in_ff.hand;
      mid_in.updated   = sample_ok;
      mid_in.have_prev = prev_valid_ff[in_ff.hand];
      mid_in.ax        = ax_full[MAG_W-1:0];
      mid_in.ay        = ay_full[MAG_W-1:0];
      mid_in.az        = az_full[MAG_W-1:0];
      mid_in.dx_pos    = !dx[DX_W-1] && (dx != '0);
      mid_in.dy_pos    = !dy[DY_W-1] && (dy != '0);
      mid_in.dz_pos    = !dz[DX_W-1] && (dz != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_vld_ff <= req_valid;
         end
         if (mid_free) begin
            mid_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_ff <= req_data;
      end
      if (mid_free && in_vld_ff) begin
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_free && in_vld_ff && sample_ok) begin
         prev_x_ff[in_ff.hand] <= x_neg;
         prev_y_ff[in_ff.hand] <= in_ff.pos_y;
         prev_z_ff[in_ff.hand] <= z_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HANDS; i++) begin
            prev_valid_ff[i] <= 1'b0;
         end
      end else if (mid_free && in_vld_ff && sample_ok) begin
         prev_valid_ff[in_ff.hand] <= 1'b1;
      end
   end

endmodule

/* rtl/hmdq_classify.sv */
// Sector and depth classification of one motion delta, and the result register.
// Depends on hmdq_pkg.
module hmdq_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  hmdq_pkg::cfg_type     cfg,
   input  logic                  mid_valid,
   output logic                  mid_ready,
   input  hmdq_pkg::delta_type   mid_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hmdq_pkg::rsp_type     rsp_data
);
   import hmdq_pkg::*;

   logic                rsp_vld_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                out_free;
   logic [PROD_W-1:0]   k_val;
   logic [PROD_W-1:0]   lo_val;
   logic [PROD_W-1:0]   hi_val;
   logic                still;
   plane_dir_type       plane;
   depth_dir_type       depth;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign mid_ready = out_free;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign k_val  = PROD_W'({mid_data.ay, 16'b0});
   assign lo_val = PROD_W'(mid_data.ax) * PROD_W'(TAN_LO);
   assign hi_val = PROD_W'(mid_data.ax) * PROD_W'(TAN_HI);
   assign still  = (mid_data.ax <= MAG_W'(cfg.xy_still_mm))
                && (mid_data.ay <= MAG_W'(cfg.xy_still_mm));

   always_comb begin
      if (still) begin
         plane = PLANE_STILL;
      end else if (k_val <= lo_val) begin
         plane = mid_data.dx_pos ? PLANE_RIGHT : PLANE_LEFT;
      end else if (k_val >= hi_val) begin
         plane = mid_data.dy_pos ? PLANE_UP : PLANE_DOWN;
      end else if (mid_data.dx_pos) begin
         plane = mid_data.dy_pos ? PLANE_UP_RIGHT : PLANE_DOWN_RIGHT;
      end else begin
         plane = mid_data.dy_pos ? PLANE_UP_LEFT : PLANE_DOWN_LEFT;
      end

      if (mid_data.az <= MAG_W'(cfg.z_still_mm)) begin
         depth = DEPTH_CENTRE;
      end else begin
         depth = mid_data.dz_pos ? DEPTH_FORWARD : DEPTH_BACKWARD;
      end

      rsp_in.out_hand = mid_data.hand;
      rsp_in.updated  = mid_data.updated;
      if (mid_data.updated && mid_data.have_prev) begin
         rsp_in.dir_plane = plane;
         rsp_in.dir_depth = depth;
      end else begin
         rsp_in.dir_plane = PLANE_VOID;
         rsp_in.dir_depth = DEPTH_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && mid_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* rtl/hand_motion_direction_quantizer_core.sv */
// Top level of the hand motion direction quantizer.
// Depends on hmdq_pkg, hmdq_csr, hmdq_delta and hmdq_classify.
//
// Usage:
//   req channel: one joint sample per item (hand, tracked, confidence, x, y, z).
//   rsp channel: one result per item (hand, updated, planar and depth direction).
//   An item is taken on an edge with valid high and stall low.
//   The csr port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the
//   planar and depth dead zones and the confidence threshold; write it only
//   while no item is in flight.
// Throughput: one item per cycle unless rsp_stall holds it; three register
//   stages (input, delta, result), with the per-hand previous position written
//   as an item enters the delta stage, so the next item of the same hand sees it.
// Reset: restores the register defaults and marks both hands as having no
//   previous position; the next sample of a hand gives void and empty.
// Stall: a stalled result holds; the stages behind it keep filling, and
//   req_stall rises only once every stage holds an item.
module hand_motion_direction_quantizer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hmdq_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hmdq_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hmdq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hmdq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hmdq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import hmdq_pkg::*;

   cfg_type   cfg;
   logic      mid_valid;
   logic      mid_ready;
   delta_type mid_data;

   hmdq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hmdq_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_data  (mid_data)
   );

   hmdq_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_data  (mid_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/hmdq_checker.sv */
// Port-level checks for the hand motion direction quantizer, bound to the top.
// Depends on hmdq_pkg and hand_motion_direction_quantizer_core.
module hmdq_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hmdq_pkg::rsp_type rsp_data
);
   import hmdq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.updated
         |-> rsp_data.dir_plane == PLANE_VOID && rsp_data.dir_depth == DEPTH_EMPTY)
      else $error("ignored sample carries a direction");

   a_void_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dir_plane == PLANE_VOID) == (rsp_data.dir_depth == DEPTH_EMPTY))
      else $error("planar and depth direction disagree on void");

endmodule

bind hand_motion_direction_quantizer_core hmdq_checker u_hmdq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/hand_motion_direction_quantizer_core_tb.sv */
// Self-checking bench for hand_motion_direction_quantizer_core: directed samples, then
// random joint tracks per hand under several dead-zone settings and idle mixes.
// Depends on hmdq_pkg and the core RTL only.
module hand_motion_direction_quantizer_core_tb;
   import hmdq_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 210;

   typedef struct {
      req_type sample;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor copy of the registers and per-hand track
   logic [STILL_W-1:0] xy_dead = XY_STILL_RST;
   logic [STILL_W-1:0] z_dead = Z_STILL_RST;
   logic [CONF_W-1:0]  conf_floor = MIN_CONF_RST;
   int                 track_x[NUM_HANDS];
   int                 track_y[NUM_HANDS];
   int                 track_z[NUM_HANDS];
   bit                 track_known[NUM_HANDS];

   logic signed [POS_BITS-1:0] sent_x[NUM_HANDS];
   logic signed [POS_BITS-1:0] sent_y[NUM_HANDS];
   logic signed [POS_BITS-1:0] sent_z[NUM_HANDS];

   rsp_type      pending_dirs[$];
   rsp_type      head;
   stim_row_type directed[$];

   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int cycles = 0;
   int n_items = 0;
   int n_updated = 0;
   int n_results = 0;
   int n_settings = 1;

   hand_motion_direction_quantizer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle);
   end

   function automatic rsp_type quantize_motion(req_type s);
      rsp_type r;
      int      x, y, z, dx, dy, dz;
      longint  ax, ay, az;
      int      h;
      h = int'(s.hand);
      r.out_hand = s.hand;
      r.updated = 1'b0;
      r.dir_plane = PLANE_VOID;
      r.dir_depth = DEPTH_EMPTY;
      if (s.tracked && s.confidence > conf_floor) begin
         x = -int'($signed(s.pos_x));
         y = int'($signed(s.pos_y));
         z = -int'($signed(s.pos_z));
         if (track_known[h]) begin
            dx = x - track_x[h];
            dy = y - track_y[h];
            dz = z - track_z[h];
            ax = longint'(dx < 0 ? -dx : dx);
            ay = longint'(dy < 0 ? -dy : dy);
            az = longint'(dz < 0 ? -dz : dz);
            if (ax <= longint'(xy_dead) && ay <= longint'(xy_dead))
               r.dir_plane = PLANE_STILL;
            else if (ay * 65536 <= longint'(TAN_LO) * ax)
               r.dir_plane = dx > 0 ? PLANE_RIGHT : PLANE_LEFT;
            else if (ay * 65536 >= longint'(TAN_HI) * ax)
               r.dir_plane = dy > 0 ? PLANE_UP : PLANE_DOWN;
            else if (dx > 0)
               r.dir_plane = dy > 0 ? PLANE_UP_RIGHT : PLANE_DOWN_RIGHT;
            else
               r.dir_plane = dy > 0 ? PLANE_UP_LEFT : PLANE_DOWN_LEFT;
            if (az <= longint'(z_dead))
               r.dir_depth = DEPTH_CENTRE;
            else
               r.dir_depth = dz > 0 ? DEPTH_FORWARD : DEPTH_BACKWARD;
         end
         track_x[h] = x;
         track_y[h] = y;
         track_z[h] = z;
         track_known[h] = 1'b1;
         r.updated = 1'b1;
      end
      return r;
   endfunction

   function automatic stim_row_type stim_row(int hand, bit tracked, int conf, int x, int y,
                                             int z, bit typed, bit upd,
                                             plane_dir_type plane, depth_dir_type depth);
      stim_row_type row;
      row.sample.hand = HAND_W'(hand);
      row.sample.tracked = tracked;
      row.sample.confidence = CONF_W'(conf);
      row.sample.pos_x = POS_BITS'(x);
      row.sample.pos_y = POS_BITS'(y);
      row.sample.pos_z = POS_BITS'(z);
      row.typed = typed;
      row.want.out_hand = HAND_W'(hand);
      row.want.updated = upd;
      row.want.dir_plane = plane;
      row.want.dir_depth = depth;
      return row;
   endfunction

   function automatic void queue_row(stim_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   // mostly plausible tracks around each hand's last position, some noise
   function automatic req_type draw_sample();
      req_type s;
      int      h, pick, span_xy, span_z;
      h = $urandom_range(0, NUM_HANDS - 1);
      pick = $urandom_range(0, 99);
      s.hand = HAND_W'(h);
      s.tracked = 1'b1;
      s.confidence = (conf_floor == 8'd255) ? 8'd255
                   : CONF_W'($urandom_range(int'(conf_floor) + 1, 255));
      case ($urandom_range(0, 3))
         0: begin
            span_xy = int'(xy_dead) + 2;
            span_z = int'(z_dead) + 2;
         end
         1: begin
            span_xy = 64;
            span_z = 64;
         end
         2: begin
            span_xy = 2000;
            span_z = 2000;
         end
         default: begin
            span_xy = 20000;
            span_z = 20000;
         end
      endcase
      if (pick < 8) begin
         s.tracked = 1'($urandom_range(0, 1));
         s.confidence = CONF_W'($urandom_range(0, 255));
         s.pos_x = POS_BITS'($urandom());
         s.pos_y = POS_BITS'($urandom());
         s.pos_z = POS_BITS'($urandom());
      end else if (pick < 18) begin
         s.pos_x = POS_BITS'($urandom());
         s.pos_y = POS_BITS'($urandom());
         s.pos_z = POS_BITS'($urandom());
      end else begin
         s.pos_x = POS_BITS'(int'(sent_x[h]) + int'($urandom_range(0, 2 * span_xy)) - span_xy);
         s.pos_y = POS_BITS'(int'(sent_y[h]) + int'($urandom_range(0, 2 * span_xy)) - span_xy);
         s.pos_z = POS_BITS'(int'(sent_z[h]) + int'($urandom_range(0, 2 * span_z)) - span_z);
      end
      sent_x[h] = s.pos_x;
      sent_y[h] = s.pos_y;
      sent_z[h] = s.pos_z;
      return s;
   endfunction

   task automatic offer_sample(req_type s, bit typed, rsp_type want);
      rsp_type predicted;
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = quantize_motion(s);
      pending_dirs.insert(pending_dirs.size(), typed ? want : predicted);
      n_items++;
      if (predicted.updated)
         n_updated++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val, logic [31:0] mask);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val | ($urandom() & ~mask);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_zones(int xy, int z, int mc);
      write_reg(REG_XY_STILL, 32'(xy), 32'h3FF);
      write_reg(REG_Z_STILL, 32'(z), 32'h3FF);
      write_reg(REG_MIN_CONF, 32'(mc), 32'hFF);
      xy_dead = STILL_W'(xy);
      z_dead = STILL_W'(z);
      conf_floor = CONF_W'(mc);
      n_settings++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_dirs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: hand %0d upd %0d plane %0d depth %0d",
                        rsp_data.out_hand, rsp_data.updated, rsp_data.dir_plane,
                        rsp_data.dir_depth);
         end else begin
            head = pending_dirs.pop_front();
            if (rsp_data.out_hand !== head.out_hand || rsp_data.updated !== head.updated ||
                rsp_data.dir_plane !== head.dir_plane ||
                rsp_data.dir_depth !== head.dir_depth) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected hand %0d upd %0d plane %0d depth %0d, %s",
                           head.out_hand, head.updated, head.dir_plane, head.dir_depth,
                           $sformatf("got hand %0d upd %0d plane %0d depth %0d",
                                     rsp_data.out_hand, rsp_data.updated,
                                     rsp_data.dir_plane, rsp_data.dir_depth));
            end
         end
      end
   end

   initial begin
      for (int h = 0; h < NUM_HANDS; h++) begin
         track_x[h] = 0;
         track_y[h] = 0;
         track_z[h] = 0;
         track_known[h] = 1'b0;
         sent_x[h] = '0;
         sent_y[h] = '0;
         sent_z[h] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 27;
      recv_idle = 86;

      queue_row(stim_row(0, 1, 255, 0, 0, 0, 1, 1, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 0, 255, 500, 500, 500, 1, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 128, 500, 500, 500, 1, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(1, 1, 0, 500, 500, 500, 1, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 129, 0, 0, 0, 1, 1, PLANE_STILL, DEPTH_CENTRE));
      queue_row(stim_row(1, 1, 200, -32768, 32767, -32768, 1, 1,
                         PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(1, 1, 200, 32767, -32768, 32767, 0, 0,
                         PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -100, 0, -100, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -200, 100, -100, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -200, 200, 0, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -100, 300, 0, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, 0, 300, 0, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, 100, 200, 0, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, 100, 100, 0, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, 0, 0, 0, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -2, 2, -20, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -5, 2, -41, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -1005, 416, -41, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -2005, 831, -41, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -2419, 1831, -41, 0, 0,
                         PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(0, 1, 200, -2834, 2831, -41, 0, 0,
                         PLANE_VOID, DEPTH_EMPTY));
      queue_row(stim_row(1, 1, 255, -1, -1, -1, 0, 0, PLANE_VOID, DEPTH_EMPTY));
      foreach (directed[i])
         offer_sample(directed[i].sample, directed[i].typed, directed[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: program_zones(0, 0, 0);
            1: program_zones(1023, 1023, 255);
            2: program_zones($urandom_range(0, 40), $urandom_range(0, 200),
                             $urandom_range(0, 254));
            3: program_zones(2, 20, 128);
            4: program_zones(1, 1023, 0);
            default: program_zones($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 255));
         endcase
         if (ph < 2) begin
            send_idle = 27;
            recv_idle = 86;
         end else if (ph < 4) begin
            send_idle = 86;
            recv_idle = 27;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         repeat (PHASE_ITEMS) offer_sample(draw_sample(), 1'b0, '0);
      end

      settle();
      repeat (8) @(posedge clock);
      errors += pending_dirs.size();
      $display("summary: %0d samples over %0d register settings, %0d updated a hand track",
               n_items, n_settings, n_updated);
      $display("summary: %0d results checked, %0d mismatches", n_results, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
